// ===== hw/rtl/asr_pkg.sv =====
// Shared types, constants and the compare-exchange rule of the argsort row engine.
// Used by asr_cell and argsort_row_engine; depends on nothing else.
`default_nettype none

package asr_pkg;

    localparam int MAX_ROW_LENGTH = 64;
    localparam int KEY_BITS       = 32;
    localparam int IDX_BITS       = $clog2(MAX_ROW_LENGTH);
    localparam int CNT_BITS       = $clog2(MAX_ROW_LENGTH + 1);

    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SORT,
        CELL_SHIFT_OUT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     parity;
        logic     desc;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } t_state;

    // True when the right entry of a pair must be placed before the left one.
    // Equal keys are ordered by ascending index in both directions.
    function automatic logic must_swap(input t_entry lft, input t_entry rgt, input logic desc);
        logic rgt_first;
        begin
            if (desc) begin
                rgt_first = $signed(rgt.key) > $signed(lft.key);
            end else begin
                rgt_first = $signed(rgt.key) < $signed(lft.key);
            end
            if (rgt.key == lft.key) begin
                rgt_first = rgt.idx < lft.idx;
            end
            must_swap = lft.valid && rgt.valid && rgt_first;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asr_cell.sv =====
// One cell of the sorting chain: holds one (index, key) entry and exchanges it
// with its neighbors. Depends on asr_pkg.
`default_nettype none

module asr_cell
    import asr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_pos_odd,
    input  wire t_entry     i_left,
    input  wire t_entry     i_right,
    output t_entry          o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_SHIFT_IN: begin
                n_entry = i_left;
            end
            CELL_SHIFT_OUT: begin
                n_entry = i_right;
            end
            CELL_SORT: begin
                if (i_pos_odd == i_ctrl.parity) begin
                    if (must_swap(r_entry, i_right, i_ctrl.desc)) begin
                        n_entry = i_right;
                    end
                end else begin
                    if (must_swap(i_left, r_entry, i_ctrl.desc)) begin
                        n_entry = i_left;
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.idx <= n_entry.idx;
        r_entry.key <= n_entry.key;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== hw/rtl/argsort_row_engine.sv =====
// Top level of the argsort row engine: control sequencer and the chain of cells.
// Depends on asr_pkg and asr_cell.
//
// Usage: keys of one row arrive on the input channel (i_in_valid, o_in_stall),
// one key per request, the last one flagged by i_row_end. Each key that is taken is
// shifted into a chain of 64 cells together with its position.
// Keys beyond the 64th of a row are dropped, but their row end still counts.
// After the row end the chain runs odd-even exchange passes, one per cycle,
// as many passes as stored keys, with the direction of i_cfg_data bit 0.
// Then the sorted pairs leave from the head cell, one per cycle while the
// receiver does not stall, the final pair flagged by o_run_last.
// A row thus passes through loading, sorting and draining in turn. The input is
// stalled from the row end until the last pair is taken. A stall on the output
// holds the head pair and the chain.
// The configuration port is always ready; reset selects ascending order.
// Reset empties the chain and returns the block to loading a new row.
`default_nettype none

module argsort_row_engine
    import asr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [KEY_BITS-1:0] i_key_value,
    input  wire logic                i_row_end,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [IDX_BITS-1:0]      o_original_index,
    output logic [KEY_BITS-1:0]      o_sorted_key,
    output logic                     o_run_last,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data
);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [CNT_BITS-1:0] r_pass;
    logic [CNT_BITS-1:0] n_pass;
    logic                r_desc;
    t_cell_ctrl          ctrl;
    t_entry              new_entry;
    t_entry              empty_entry;
    t_entry              cells [MAX_ROW_LENGTH];
    logic                in_take;
    logic                out_take;

    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = o_out_valid && !i_out_stall;

    assign new_entry.valid = (r_state == ST_LOAD);
    assign new_entry.idx   = r_count[IDX_BITS-1:0];
    assign new_entry.key   = i_key_value;

    assign empty_entry.valid = 1'b0;
    assign empty_entry.idx   = '0;
    assign empty_entry.key   = '0;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pass      = r_pass;
        ctrl.op     = CELL_HOLD;
        ctrl.parity = r_pass[0];
        ctrl.desc   = r_desc;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (in_take) begin
                    if (r_count < CNT_BITS'(MAX_ROW_LENGTH)) begin
                        ctrl.op = CELL_SHIFT_IN;
                        n_count = r_count + 1'b1;
                    end
                    if (i_row_end) begin
                        n_state = ST_SORT;
                        n_pass  = '0;
                    end
                end
            end
            ST_SORT: begin
                if (r_pass == r_count) begin
                    n_state = ST_DRAIN;
                end else begin
                    ctrl.op = CELL_SORT;
                    n_pass  = r_pass + 1'b1;
                end
            end
            ST_DRAIN: begin
                o_out_valid = 1'b1;
                if (out_take) begin
                    ctrl.op = CELL_SHIFT_OUT;
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_BITS'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_pass  <= '0;
            r_desc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pass  <= n_pass;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    for (genvar g = 0; g < MAX_ROW_LENGTH; g++) begin : g_cell
        t_entry left_in;
        t_entry right_in;

        if (g == 0) begin : g_head
            assign left_in = new_entry;
        end else begin : g_body
            assign left_in = cells[g-1];
        end

        if (g == MAX_ROW_LENGTH - 1) begin : g_tail
            assign right_in = empty_entry;
        end else begin : g_inner
            assign right_in = cells[g+1];
        end

        asr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_pos_odd (1'(g % 2)),
            .i_left    (left_in),
            .i_right   (right_in),
            .o_entry   (cells[g])
        );
    end

    assign o_original_index = cells[0].idx;
    assign o_sorted_key     = cells[0].key;
    assign o_run_last       = (r_count == CNT_BITS'(1));

endmodule

`default_nettype wire

// ===== bench/argsort_checker.sv =====
`timescale 1ns / 100ps
// Checker for the argsort row engine: watches the key, pair and direction channels,
// predicts each sorted row with a stable sort and compares every pair field by field.
// Depends on asr_pkg for the row length, key width and index width.
module argsort_checker
    import asr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [KEY_BITS-1:0] i_key_value,
    input  logic                i_row_end,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [IDX_BITS-1:0] i_original_index,
    input  logic [KEY_BITS-1:0] i_sorted_key,
    input  logic                i_run_last,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    input  logic                i_done,
    output int                  o_failures,
    output int                  o_pending,
    output int                  o_rows,
    output int                  o_pairs
);

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic [KEY_BITS-1:0] key;
        logic                last;
    } t_sorted_pair;

    logic [KEY_BITS-1:0] row_keys [MAX_ROW_LENGTH];
    int                  keys_held;
    logic                descending;
    t_sorted_pair        sorted_pairs_q[$];
    logic                done_seen;

    initial begin
        o_failures    = 0;
        o_pending     = 0;
        o_rows        = 0;
        o_pairs       = 0;
        keys_held     = 0;
        descending    = 1'b0;
        done_seen     = 1'b0;
    end

    function automatic logic key_precedes(input logic [KEY_BITS-1:0] a,
                                          input logic [KEY_BITS-1:0] b,
                                          input logic desc);
        return desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_failures++;
    endtask

    // Insertion sort on positions with a strict compare, so that tied keys
    // leave in ascending position order in either direction.
    task automatic queue_sorted_row();
        int           order [MAX_ROW_LENGTH];
        int           i;
        int           pos;
        int           cur;
        t_sorted_pair pair;
        for (i = 0; i < keys_held; i++) begin
            order[i] = i;
        end
        for (i = 1; i < keys_held; i++) begin
            cur = order[i];
            pos = i;
            while (pos > 0 && key_precedes(row_keys[cur], row_keys[order[pos-1]], descending)) begin
                order[pos] = order[pos-1];
                pos--;
            end
            order[pos] = cur;
        end
        for (i = 0; i < keys_held; i++) begin
            pair.idx  = IDX_BITS'(order[i]);
            pair.key  = row_keys[order[i]];
            pair.last = (i == keys_held - 1);
            sorted_pairs_q = {sorted_pairs_q, pair};
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_pair want;
        if (!i_rst_n) begin
            keys_held  = 0;
            descending = 1'b0;
            sorted_pairs_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                descending = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (sorted_pairs_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pair index %0d key %0d last %b",
                                              i_original_index, $signed(i_sorted_key),
                                              i_run_last));
                end else begin
                    want = sorted_pairs_q.pop_front();
                    if (i_original_index !== want.idx) begin
                        report_mismatch($sformatf("original_index %0d, expected %0d",
                                                  i_original_index, want.idx));
                    end
                    if (i_sorted_key !== want.key) begin
                        report_mismatch($sformatf("sorted_key %0d, expected %0d",
                                                  $signed(i_sorted_key), $signed(want.key)));
                    end
                    if (i_run_last !== want.last) begin
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  i_run_last, want.last));
                    end
                    o_pairs++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (keys_held < MAX_ROW_LENGTH) begin
                    row_keys[keys_held] = i_key_value;
                    keys_held++;
                end
                if (i_row_end) begin
                    queue_sorted_row();
                    keys_held = 0;
                    o_rows++;
                end
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (sorted_pairs_q.size() != 0) begin
                    report_mismatch($sformatf("%0d sorted pairs never arrived",
                                              sorted_pairs_q.size()));
                end
            end
        end
        o_pending = sorted_pairs_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the argsort row engine testbench: clock, reset, key and direction requests,
// random stalls, a watchdog and the verdict. Depends on asr_pkg, argsort_row_engine
// and argsort_checker.
module tb;
    import asr_pkg::*;

    localparam int   RANDOM_ITEMS  = 150;
    localparam int   IDLE_LIMIT    = 4000;
    localparam int   SETTLE_CYCLES = 16;
    localparam logic DIR_ASCENDING  = 1'b0;
    localparam logic DIR_DESCENDING = 1'b1;
    localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic [KEY_BITS-1:0] EDGE_KEYS [9] = '{
        KEY_MAX, KEY_MIN, 32'h0, 32'hffff_ffff, 32'h1, 32'h0, KEY_MAX, KEY_MIN, 32'h5
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [KEY_BITS-1:0] key_value;
    logic                row_end;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [IDX_BITS-1:0] original_index;
    logic [KEY_BITS-1:0] sorted_key;
    logic                run_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;
    logic                done;
    bit                  calm = 1'b0;
    int                  failures;
    int                  pending;
    int                  rows;
    int                  pairs;
    int                  idle_cycles = 0;

    argsort_row_engine u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_key_value      (key_value),
        .i_row_end        (row_end),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_original_index (original_index),
        .o_sorted_key     (sorted_key),
        .o_run_last       (run_last),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    argsort_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_key_value      (key_value),
        .i_row_end        (row_end),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_original_index (original_index),
        .i_sorted_key     (sorted_key),
        .i_run_last       (run_last),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_done           (done),
        .o_failures       (failures),
        .o_pending        (pending),
        .o_rows           (rows),
        .o_pairs          (pairs)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall = !calm && ($urandom_range(0, 99) < 20);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [KEY_BITS-1:0] random_key();
        case ($urandom_range(0, 3))
            0: random_key = KEY_BITS'($urandom_range(0, 6)) - KEY_BITS'(3);
            1: random_key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            default: random_key = $urandom;
        endcase
    endfunction

    task automatic send_key(input logic [KEY_BITS-1:0] key, input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 20) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        key_value = key;
        row_end   = last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_direction(input logic dir);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = dir;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        int k;
        bit long_done;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        key_value = '0;
        row_end   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = DIR_ASCENDING;
        done      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_direction(DIR_ASCENDING);
        send_key(KEY_MIN, 1'b1);
        for (k = 0; k < 9; k++) begin
            send_key(EDGE_KEYS[k], k == 8);
        end
        wait_idle();
        write_direction(DIR_DESCENDING);
        for (k = 0; k < 9; k++) begin
            send_key(EDGE_KEYS[k], k == 8);
        end
        send_key(32'hffff_ffff, 1'b0);
        send_key(32'hffff_ffff, 1'b1);
        send_key(KEY_MAX, 1'b1);

        sent      = 0;
        long_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_direction($urandom_range(0, 1) ? DIR_DESCENDING : DIR_ASCENDING);
            end
            calm = 1'b0;
            if (!long_done && sent >= RANDOM_ITEMS / 3) begin
                len       = MAX_ROW_LENGTH + 2;
                long_done = 1'b1;
                calm      = 1'b1;
            end else begin
                len = $urandom_range(1, 10);
            end
            for (k = 0; k < len; k++) begin
                send_key(random_key(), k == len - 1);
            end
            sent += len;
        end
        calm = 1'b0;

        wait_idle();
        done = 1'b1;
        repeat (2) @(negedge clk);
        $display("Run covered %0d rows and %0d sorted pairs, ascending and descending,",
                 rows, pairs);
        $display("with single-key rows, tied and extreme keys, and a row past %0d keys.",
                 MAX_ROW_LENGTH);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/asr_pkg.sv
hw/rtl/asr_cell.sv
hw/rtl/argsort_row_engine.sv
bench/argsort_checker.sv
bench/tb.sv
